// File: rtl/core/dq_pkg.sv
// Shared types and constants of the double-ended queue.
package dq_pkg;

    localparam int DQ_DEPTH      = 16;
    localparam int DQ_WORD_WIDTH = 32;

    localparam int DQ_ACT_W     = 3;
    localparam int DQ_DATA_W    = 32;
    localparam int DQ_STATUS_W  = 2;
    localparam int DQ_S_BITS    = DQ_ACT_W + DQ_DATA_W;
    localparam int DQ_S_TDATA_W = ((DQ_S_BITS + 7) / 8) * 8;

    localparam int DQ_Q_DEPTH = 2;
    localparam int DQ_Q_PTR_W = $clog2(DQ_Q_DEPTH);
    localparam int DQ_Q_CNT_W = $clog2(DQ_Q_DEPTH + 1);

    typedef enum logic [DQ_ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_REVERSE    = 3'd4,
        ACT_LOOK       = 3'd5
    } dq_action_t;

    typedef enum logic [DQ_STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } dq_status_t;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_REV,
        OP_LOOK
    } dq_kind_t;

    // One classified operation handed from the front part to the back part.
    typedef struct packed {
        dq_kind_t               kind;
        logic                   front_end;  // 1: logical front, 0: logical back
        logic [DQ_DATA_W-1:0]   word;
    } dq_op_t;

    typedef enum logic [1:0] {
        BK_EXEC,
        BK_READ,
        BK_SEND
    } dq_state_t;

endpackage

// File: rtl/core/double_ended_queue.sv
// Top level of the bounded double-ended queue.
//
// Each input transaction on the s_ channel carries an action and a word:
// push at the front or back, pop from the front or back, reverse, or look.
// Each one yields exactly one result transaction on the m_ channel with the
// status, the front and back words, the entry count and an empty flag, all
// describing the queue after the action.
// A front part decodes actions into a two-entry queue; a back part executes
// them against the ring store. The back part takes each item through three
// steps in its sequencer (execute, registered store read, result load) and
// takes no new item until the result is loaded into the result register.
// Reset (aresetn low, synchronous) empties the queue, clears the reverse
// state and drops any queued or pending transaction; the store contents are
// not cleared. When the receiver holds m_tready low, the result waits in
// its register, the back part stops after reading the next item's words,
// and s_tready falls once the two-entry queue fills.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = DQ_DEPTH,
    parameter int WORD_WIDTH = DQ_WORD_WIDTH,
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int M_BITS     = DQ_STATUS_W + 2 * DQ_DATA_W + CNT_W + 1,
    localparam int M_TDATA_W  = ((M_BITS + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [DQ_S_TDATA_W-1:0] s_tdata,   // action, data_word
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_W-1:0]    m_tdata    // status, front_word, back_word,
                                               // entry_count, is_empty
);

    logic                  op_valid;
    logic                  op_ready;
    dq_op_t                op;
    dq_status_t            res_status;
    logic [DQ_DATA_W-1:0]  res_front;
    logic [DQ_DATA_W-1:0]  res_back;
    logic [CNT_W-1:0]      res_count;
    logic                  res_empty;

    // Decode and buffer incoming transactions.
    dq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    // Execute operations and hold the result for the downstream receiver.
    dq_back #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op         (op),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_front  (res_front),
        .res_back   (res_back),
        .res_count  (res_count),
        .res_empty  (res_empty)
    );

    // Fields are packed from the lowest bit up, padded with zeros to bytes.
    assign m_tdata = M_TDATA_W'({res_empty, res_count, res_back, res_front, res_status});

`ifndef SYNTHESIS
    // The count never goes beyond the ring size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_count <= CNT_W'(DEPTH)))
        else $error("entry count above depth");

    // The empty flag agrees with the count.
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_empty == (res_count == '0)))
        else $error("empty flag disagrees with count");

    // An empty queue reports zero words at both ends.
    a_empty_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_empty) |-> (res_front == '0 && res_back == '0))
        else $error("words reported on empty queue");

    // A push refused as full leaves the queue full.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_status == ST_FULL) |-> (res_count == CNT_W'(DEPTH)))
        else $error("full refusal on a queue that is not full");

    // A refusal because empty comes only from an empty queue.
    a_empty_refusal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_status == ST_EMPTY) |-> res_empty)
        else $error("empty refusal on a queue holding words");
`endif

endmodule

// File: rtl/core/dq_front.sv
// Front part: accepts transactions, decodes the action and queues operations.
module dq_front
    import dq_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [DQ_S_TDATA_W-1:0] s_tdata,
    output logic                    op_valid,
    input  logic                    op_ready,
    output dq_op_t                  op
);

    dq_op_t                  entry_reg [DQ_Q_DEPTH];
    logic [DQ_Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [DQ_Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [DQ_Q_CNT_W-1:0]   q_cnt_reg, q_cnt_next;
    dq_op_t                  dec_op;
    dq_action_t              act;
    logic                    push, pop;

    assign act = dq_action_t'(s_tdata[DQ_ACT_W-1:0]);

    // Codes six and seven carry no meaning and act as a look.
    always_comb begin
        dec_op.word      = s_tdata[DQ_S_BITS-1:DQ_ACT_W];
        dec_op.front_end = 1'b1;
        dec_op.kind      = OP_LOOK;
        unique case (act)
            ACT_PUSH_FRONT: dec_op.kind = OP_PUSH;
            ACT_PUSH_BACK: begin
                dec_op.kind      = OP_PUSH;
                dec_op.front_end = 1'b0;
            end
            ACT_POP_FRONT: dec_op.kind = OP_POP;
            ACT_POP_BACK: begin
                dec_op.kind      = OP_POP;
                dec_op.front_end = 1'b0;
            end
            ACT_REVERSE: dec_op.kind = OP_REV;
            default: dec_op.kind = OP_LOOK;
        endcase
    end

    assign s_tready = (q_cnt_reg != DQ_Q_CNT_W'(DQ_Q_DEPTH));
    assign op_valid = (q_cnt_reg != '0);
    assign op       = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = op_valid && op_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg + DQ_Q_CNT_W'(push) - DQ_Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= dec_op;
        end
    end

endmodule

// File: rtl/core/dq_back.sv
// Back part: ring store, pointer update sequencer and result register.
module dq_back
    import dq_pkg::*;
#(
    parameter int DEPTH      = DQ_DEPTH,
    parameter int WORD_WIDTH = DQ_WORD_WIDTH,
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   op_valid,
    output logic                   op_ready,
    input  dq_op_t                 op,
    output logic                   res_valid,
    input  logic                   res_ready,
    output dq_status_t             res_status,
    output logic [DQ_DATA_W-1:0]   res_front,
    output logic [DQ_DATA_W-1:0]   res_back,
    output logic [CNT_W-1:0]       res_count,
    output logic                   res_empty
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = CNT_W + 1;

    logic [WORD_WIDTH-1:0] mem [DEPTH];

    dq_state_t              state_reg, state_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   flag_reg, flag_next;
    dq_status_t             status_reg, status_next;
    logic [WORD_WIDTH-1:0]  rd_lo_reg, rd_hi_reg;
    logic                   out_valid_reg;
    dq_status_t             out_status_reg;
    logic [DQ_DATA_W-1:0]   out_front_reg, out_back_reg;
    logic [CNT_W-1:0]       out_count_reg;
    logic                   out_empty_reg;

    logic                   exec_fire, rd_en, load_out;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic                   at_bottom, is_full, is_empty;
    logic [IDX_W-1:0]       head_inc, head_dec, tail_addr, top_addr;
    logic [SUM_W-1:0]       sum;
    logic [WORD_WIDTH-1:0]  sel_front, sel_back;

    function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] r;
        r = (x >= SUM_W'(DEPTH)) ? x - SUM_W'(DEPTH) : x;
        return r[IDX_W-1:0];
    endfunction

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_EXEC: if (op_valid) state_next = BK_READ;
            BK_READ: state_next = BK_SEND;
            BK_SEND: if (!out_valid_reg || res_ready) state_next = BK_EXEC;
            default: state_next = BK_EXEC;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        op_ready = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_EXEC: op_ready = 1'b1;
            BK_READ: rd_en = 1'b1;
            BK_SEND: load_out = !out_valid_reg || res_ready;
            default: op_ready = 1'b0;
        endcase
    end

    assign exec_fire = op_valid && op_ready;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign at_bottom = op.front_end != flag_reg;
    assign head_inc  = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec  = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign sum       = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_addr = wrap(sum);
    assign top_addr  = is_empty ? head_reg : wrap(sum - 1'b1);

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        flag_next   = flag_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_addr;
        if (exec_fire) begin
            status_next = ST_DONE;
            unique case (op.kind)
                OP_PUSH: begin
                    if (is_full) begin
                        status_next = ST_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (at_bottom) begin
                            head_next = head_dec;
                            wr_addr   = head_dec;
                        end
                    end
                end
                OP_POP: begin
                    if (is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        count_next = count_reg - 1'b1;
                        if (at_bottom) begin
                            head_next = head_inc;
                        end
                    end
                end
                OP_REV: begin
                    if (is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        flag_next = !flag_reg;
                    end
                end
                default: status_next = ST_DONE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= WORD_WIDTH'(op.word);
        end
        if (rd_en) begin
            rd_lo_reg <= mem[head_reg];
            rd_hi_reg <= mem[top_addr];
        end
    end

    assign sel_front = flag_reg ? rd_hi_reg : rd_lo_reg;
    assign sel_back  = flag_reg ? rd_lo_reg : rd_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_EXEC;
            head_reg      <= '0;
            count_reg     <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (load_out) begin
            out_status_reg <= status_reg;
            out_front_reg  <= is_empty ? '0 : DQ_DATA_W'(sel_front);
            out_back_reg   <= is_empty ? '0 : DQ_DATA_W'(sel_back);
            out_count_reg  <= count_reg;
            out_empty_reg  <= is_empty;
        end
    end

    assign res_valid  = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_front  = out_front_reg;
    assign res_back   = out_back_reg;
    assign res_count  = out_count_reg;
    assign res_empty  = out_empty_reg;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the double-ended queue with a scoreboard and stream drivers.
module tb
    import dq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The result bus layout follows the port comment of the top level.
    // From the lowest bit up it holds status, front_word, back_word,
    // entry_count and is_empty.
    localparam int CNT_W      = $clog2(DQ_DEPTH + 1);
    localparam int IDX_W      = $clog2(DQ_DEPTH);
    localparam int M_BITS     = DQ_STATUS_W + 2 * DQ_DATA_W + CNT_W + 1;
    localparam int M_TDATA_W  = ((M_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 500;
    localparam int CALM_TAIL    = 80;
    // No transaction for this many cycles in a row means the block is stuck.
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 20;

    // One result transaction, split into its fields.
    typedef struct {
        logic [DQ_STATUS_W-1:0] status;
        logic [DQ_DATA_W-1:0]   front_word;
        logic [DQ_DATA_W-1:0]   back_word;
        logic [CNT_W-1:0]       entry_count;
        logic                   is_empty;
    } deque_view_t;

    // The scoreboard keeps its own copy of the queue. Each accepted action
    // is applied to that copy, and the view of the queue that follows is
    // stored until the matching result transaction comes back.
    class deque_scoreboard;
        logic [DQ_DATA_W-1:0] ring [DQ_DEPTH];
        logic [IDX_W-1:0]     bottom;
        logic [CNT_W-1:0]     held;
        logic                 flipped;
        deque_view_t          awaited_views [$];
        int                   errors;

        function new();
            foreach (ring[i]) ring[i] = '0;
            bottom  = '0;
            held    = '0;
            flipped = 1'b0;
            errors  = 0;
        endfunction

        function int pending();
            return awaited_views.size();
        endfunction

        task report_mismatch(input string what, input logic [63:0] got,
                             input logic [63:0] want);
            $display("%0t ns: mismatch in %s: got %0h, expected %0h",
                     $realtime, what, got, want);
            errors++;
        endtask

        // Apply one accepted action and queue the resulting view.
        function void note_action(input logic [DQ_ACT_W-1:0] act,
                                  input logic [DQ_DATA_W-1:0] word);
            deque_view_t      view;
            logic             at_bottom;
            logic [IDX_W-1:0] top;

            view.status = ST_DONE;
            case (act)
                ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                    if (held == CNT_W'(DQ_DEPTH)) begin
                        view.status = ST_FULL;
                    end else begin
                        // While reversed, the logical front sits at the top.
                        at_bottom = (act == ACT_PUSH_FRONT) != flipped;
                        if (at_bottom) begin
                            bottom = bottom - 1'b1;
                            ring[bottom] = word;
                        end else begin
                            ring[IDX_W'(bottom + held)] = word;
                        end
                        held = held + 1'b1;
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK: begin
                    if (held == '0) begin
                        view.status = ST_EMPTY;
                    end else begin
                        at_bottom = (act == ACT_POP_FRONT) != flipped;
                        if (at_bottom) begin
                            bottom = bottom + 1'b1;
                        end
                        held = held - 1'b1;
                    end
                end
                ACT_REVERSE: begin
                    if (held == '0) begin
                        view.status = ST_EMPTY;
                    end else begin
                        flipped = ~flipped;
                    end
                end
                default: begin
                    // Look, and the two unused codes, change nothing.
                end
            endcase

            view.front_word  = '0;
            view.back_word   = '0;
            view.entry_count = held;
            view.is_empty    = (held == '0);
            if (held != '0) begin
                top = IDX_W'(bottom + held - 1'b1);
                view.front_word = flipped ? ring[top] : ring[bottom];
                view.back_word  = flipped ? ring[bottom] : ring[top];
            end
            awaited_views.push_back(view);
        endfunction

        // Compare one accepted result with the oldest awaited view.
        task check_result(input logic [M_TDATA_W-1:0] bus);
            deque_view_t want;
            deque_view_t got;

            got.status      = bus[DQ_STATUS_W-1:0];
            got.front_word  = bus[DQ_STATUS_W +: DQ_DATA_W];
            got.back_word   = bus[DQ_STATUS_W + DQ_DATA_W +: DQ_DATA_W];
            got.entry_count = bus[DQ_STATUS_W + 2 * DQ_DATA_W +: CNT_W];
            got.is_empty    = bus[M_BITS-1];
            if (awaited_views.size() == 0) begin
                report_mismatch("result with nothing awaited", bus[63:0], '0);
            end else begin
                want = awaited_views.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.front_word !== want.front_word)
                    report_mismatch("front_word", 64'(got.front_word),
                                    64'(want.front_word));
                if (got.back_word !== want.back_word)
                    report_mismatch("back_word", 64'(got.back_word),
                                    64'(want.back_word));
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(got.entry_count),
                                    64'(want.entry_count));
                if (got.is_empty !== want.is_empty)
                    report_mismatch("is_empty", 64'(got.is_empty),
                                    64'(want.is_empty));
            end
        endtask
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [DQ_S_TDATA_W-1:0] s_tdata;   // action, data_word
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;   // status, front_word, back_word,
                                        // entry_count, is_empty

    deque_scoreboard sb;
    // Once set, neither side inserts idle cycles any more.
    logic calm;
    int   quiet_cycles;

    double_ended_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Every transaction on either side is seen here at the rising edge.
    // Inputs go to the scoreboard's copy of the queue, results are checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_action(s_tdata[DQ_ACT_W-1:0],
                               s_tdata[DQ_ACT_W +: DQ_DATA_W]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
        end
    end

    // Watchdog: the run ends as failed if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // The receiver takes results, with random stalls until the calm tail of
    // the run.
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!calm && aresetn && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    // Offer one action and hold it until the block takes it. A random gap
    // may come first; with no gap, tvalid simply stays high.
    task automatic send_action(input logic [DQ_ACT_W-1:0] act,
                               input logic [DQ_DATA_W-1:0] word);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = '0;
        s_tdata[DQ_ACT_W-1:0]         = act;
        s_tdata[DQ_ACT_W +: DQ_DATA_W] = word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop sending until every awaited result has arrived.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // Random word, leaning now and then on all zeros or all ones.
    function automatic logic [DQ_DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sent;
        int run_len;
        int mode;
        int phase;
        logic [DQ_ACT_W-1:0] act;

        sb           = new();
        calm         = 1'b0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed part. Start with a look and every refusal on an empty queue,
        // then an unused action code, which must behave like a look.
        send_action(ACT_LOOK, 32'hFFFF_FFFF);
        send_action(ACT_POP_FRONT, '0);
        send_action(ACT_POP_BACK, '0);
        send_action(ACT_REVERSE, '0);
        send_action(3'd6, 32'h1234_5678);
        // Fill the queue from both ends with extreme and mixed words.
        for (int i = 0; i < DQ_DEPTH; i++) begin
            act = i[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            if (i == 0)
                send_action(act, '0);
            else if (i == 1)
                send_action(act, '1);
            else if (i == 2)
                send_action(act, 32'hAAAA_AAAA);
            else if (i == 3)
                send_action(act, 32'h5555_5555);
            else
                send_action(act, $urandom);
        end
        // A full queue refuses pushes at either end.
        send_action(ACT_PUSH_FRONT, 32'hDEAD_BEEF);
        send_action(ACT_PUSH_BACK, 32'hCAFE_F00D);
        // Reverse a full queue and take one word off each end.
        send_action(ACT_REVERSE, '0);
        send_action(ACT_POP_FRONT, '0);
        send_action(ACT_POP_BACK, '0);
        send_action(3'd7, '1);

        // Random part, in phases that grow the queue, shrink it, or mix
        // everything, so that both the full and the empty ends are reached
        // often and reversal happens at many fill levels.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(10, 40);
            for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
                if (sent >= RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
                case (mode)
                    0: act = ($urandom_range(0, 3) != 0) ? DQ_ACT_W'($urandom_range(0, 1))
                                                         : DQ_ACT_W'($urandom_range(0, 7));
                    1: act = ($urandom_range(0, 3) != 0) ? DQ_ACT_W'($urandom_range(2, 3))
                                                         : DQ_ACT_W'($urandom_range(0, 7));
                    2: act = DQ_ACT_W'($urandom_range(0, 7));
                    default: act = DQ_ACT_W'($urandom_range(0, 5));
                endcase
                send_action(act, pick_word());
                sent++;
            end
            // The sender now and then holds off until every result is back,
            // and always does so after the second phase. The calm tail runs
            // without such pauses.
            if (phase == 1 || (!calm && $urandom_range(0, 3) == 0)) wait_drained();
            phase++;
        end
        s_tvalid = 1'b0;

        // Wait for the last results, then a little longer to catch strays.
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/dq_pkg.sv
rtl/core/dq_front.sv
rtl/core/dq_back.sv
rtl/core/double_ended_queue.sv
bench/tb.sv
